@@ rtl/stxr_pkg.sv @@
// Shared types, constants and 5x7 column font for the scrolling text frame renderer.
package stxr_pkg;

  // Glyph geometry and printable code range
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_GAP   = 1;
  localparam int STORE_ROWS  = 8;
  localparam int STORE_COLS  = 8;
  localparam int FONT_DEPTH  = 95;
  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd126;

  // Cursor limits
  localparam logic signed [16:0] CURSOR_MAX = 17'sd32767;

  // Configuration register indexes
  localparam logic REG_TEXT_COLOR = 1'b0;
  localparam logic REG_BRIGHTNESS = 1'b1;

  // One frame of lit-pixel masks, row r in element r
  typedef logic [STORE_ROWS-1:0][STORE_COLS-1:0] frame_t;

  // Frame hand-off from the draw stage to the row emitter
  typedef struct packed {
    logic   load;
    frame_t rows;
  } snap_t;

  // Font: column 0 in bits 39:32 ... column 4 in bits 7:0; bit r of a column lights row r
  localparam logic [39:0] FONT [FONT_DEPTH] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413e, 40'h7e1111117e, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h0c5252523e, 40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
    40'h4464544c44, 40'h0008364100, 40'h00007f0000, 40'h0041360800, 40'h0804081008
  };

  // Map a character byte to its font entry; non-printable codes map to space
  function automatic logic [6:0] glyph_index(input logic [7:0] code);
    logic [7:0] diff;
    diff = code - CODE_FIRST;
    if (code < CODE_FIRST || code > CODE_LAST) begin
      glyph_index = 7'd0;
    end else begin
      glyph_index = diff[6:0];
    end
  endfunction

endpackage

@@ rtl/scrolling_text_frame_render_top.sv @@
// Top level of the scrolling text frame renderer: config registers, draw stage, row emitter.
// Each input item is one character; the block takes one item per cycle unless a last item
// waits in the input register for the emitter. A character is registered, then drawn into
// the frame store by combinational glyph lookup and column OR logic. An item marked
// last also hands the finished frame to the row emitter, which gives min(MATRIX_HEIGHT, 8)
// row items, one per cycle while out_ready is high. Characters of the next text may
// be drawn while those rows are still going out; a further last item waits in the input
// register only until the emitter's final row is accepted. Registers: index 0 is the
// 24-bit text color, index 1 the requested brightness (clamped to MAX_BRIGHTNESS).
module scrolling_text_frame_render_top #(
  parameter int MATRIX_WIDTH   = 8,
  parameter int MATRIX_HEIGHT  = 8,
  parameter int MAX_BRIGHTNESS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char_code,
  input  logic                in_start_frame,
  input  logic signed [15:0]  in_offset_x,
  input  logic                in_last_char,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_row_index,
  output logic [7:0]          out_row_pixels,
  output logic [23:0]         out_pixel_color,
  output logic [7:0]          out_brightness,
  output logic                out_last_row
);

  logic [23:0]      text_color_r;
  logic [7:0]       req_bright_r;
  stxr_pkg::snap_t  snap;
  logic             snap_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= '0;
      req_bright_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stxr_pkg::REG_TEXT_COLOR: text_color_r <= cfg_data;
        stxr_pkg::REG_BRIGHTNESS: req_bright_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  stxr_draw #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT)
  ) u_draw (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_start_frame (in_start_frame),
    .in_offset_x    (in_offset_x),
    .in_last_char   (in_last_char),
    .snap_ready     (snap_ready),
    .snap           (snap)
  );

  stxr_emit #(
    .MATRIX_HEIGHT  (MATRIX_HEIGHT),
    .MAX_BRIGHTNESS (MAX_BRIGHTNESS)
  ) u_emit (
    .clk                  (clk),
    .rst_n                (rst_n),
    .snap                 (snap),
    .snap_ready           (snap_ready),
    .text_color           (text_color_r),
    .requested_brightness (req_bright_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_row_index        (out_row_index),
    .out_row_pixels       (out_row_pixels),
    .out_pixel_color      (out_pixel_color),
    .out_brightness       (out_brightness),
    .out_last_row         (out_last_row)
  );

endmodule

@@ rtl/stxr_draw.sv @@
// Input register, glyph draw logic, working frame store and text cursor.
module stxr_draw #(
  parameter int MATRIX_WIDTH  = 8,
  parameter int MATRIX_HEIGHT = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_char_code,
  input  logic                 in_start_frame,
  input  logic signed [15:0]   in_offset_x,
  input  logic                 in_last_char,
  input  logic                 snap_ready,
  output stxr_pkg::snap_t      snap
);

  localparam int VIS_W = (MATRIX_WIDTH < stxr_pkg::STORE_COLS) ? MATRIX_WIDTH
                                                                 : stxr_pkg::STORE_COLS;

  // Input stage
  logic                s1_valid_r;
  logic [7:0]          s1_code_r;
  logic                s1_start_r;
  logic signed [15:0]  s1_offset_r;
  logic                s1_last_r;
  logic                s1_fire;

  // Working state
  stxr_pkg::frame_t    frame_r, frame_nxt;
  logic signed [15:0]  cursor_r, cursor_nxt;

  // Draw datapath
  stxr_pkg::frame_t    base_frame;
  logic signed [15:0]  base_cur;
  logic [39:0]         glyph;
  logic signed [16:0]  col_off;
  logic [7:0]          col_bits;
  logic signed [16:0]  cur_sum;
  logic [2:0]          advance;

  // Stage 1 moves on unless a last item waits for the emitter
  assign s1_fire  = s1_valid_r && (!s1_last_r || snap_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_code_r   <= in_char_code;
      s1_start_r  <= in_start_frame;
      s1_offset_r <= in_offset_x;
      s1_last_r   <= in_last_char;
    end
  end

  // Draw the glyph into the (possibly cleared) frame, one column per matrix x
  always_comb begin
    base_frame = s1_start_r ? '0 : frame_r;
    base_cur   = s1_start_r ? s1_offset_r : cursor_r;
    glyph      = stxr_pkg::FONT[stxr_pkg::glyph_index(s1_code_r)];
    frame_nxt  = base_frame;
    col_off    = '0;
    col_bits   = '0;
    for (int x = 0; x < VIS_W; x++) begin
      col_off = 17'(x) - 17'(base_cur);
      if (col_off >= 17'sd0 && col_off < 17'(stxr_pkg::GLYPH_COLS)) begin
        col_bits = glyph[39 - 8 * col_off[2:0] -: 8];
        for (int r = 0; r < stxr_pkg::GLYPH_ROWS; r++) begin
          if (r < MATRIX_HEIGHT && col_bits[r]) begin
            frame_nxt[r][x] = 1'b1;
          end
        end
      end
    end
  end

  // Cursor advance, saturating at the top of the int16 range
  always_comb begin
    advance = s1_last_r ? 3'(stxr_pkg::GLYPH_COLS)
                        : 3'(stxr_pkg::GLYPH_COLS + stxr_pkg::GLYPH_GAP);
    cur_sum = 17'(base_cur) + 17'(advance);
    if (cur_sum > stxr_pkg::CURSOR_MAX) begin
      cursor_nxt = 16'(stxr_pkg::CURSOR_MAX);
    end else begin
      cursor_nxt = cur_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= '0;
      cursor_r <= '0;
    end else if (s1_fire) begin
      frame_r  <= frame_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  // Finished frame goes to the emitter on the last item
  assign snap.load = s1_fire && s1_last_r;
  assign snap.rows = frame_nxt;

endmodule

@@ rtl/stxr_emit.sv @@
// Frame snapshot and row sequencer that hands out one row item per cycle while out_ready is high.
module stxr_emit #(
  parameter int MATRIX_HEIGHT  = 8,
  parameter int MAX_BRIGHTNESS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  stxr_pkg::snap_t  snap,
  output logic             snap_ready,
  input  logic [23:0]      text_color,
  input  logic [7:0]       requested_brightness,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_row_index,
  output logic [7:0]       out_row_pixels,
  output logic [23:0]      out_pixel_color,
  output logic [7:0]       out_brightness,
  output logic             out_last_row
);

  localparam int ROWS_OUT = (MATRIX_HEIGHT < stxr_pkg::STORE_ROWS) ? MATRIX_HEIGHT
                                                                    : stxr_pkg::STORE_ROWS;
  localparam logic [2:0] LAST_ROW = 3'(ROWS_OUT - 1);
  localparam logic [7:0] BRIGHT_MAX = 8'(MAX_BRIGHTNESS);

  logic              valid_r;
  logic [2:0]        row_r;
  stxr_pkg::frame_t  rows_r;
  logic [23:0]       color_r;
  logic [7:0]        bright_r;
  logic              at_last;

  assign at_last    = (row_r == LAST_ROW);
  assign snap_ready = !valid_r || (out_ready && at_last);

  // Row sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      row_r   <= '0;
    end else if (snap.load) begin
      valid_r <= 1'b1;
      row_r   <= '0;
    end else if (valid_r && out_ready) begin
      if (at_last) begin
        valid_r <= 1'b0;
      end else begin
        row_r <= row_r + 3'd1;
      end
    end
  end

  // Snapshot of frame, color and clamped brightness
  always_ff @(posedge clk) begin
    if (snap.load) begin
      rows_r   <= snap.rows;
      color_r  <= text_color;
      bright_r <= (requested_brightness > BRIGHT_MAX) ? BRIGHT_MAX : requested_brightness;
    end
  end

  assign out_valid       = valid_r;
  assign out_row_index   = row_r;
  assign out_row_pixels  = rows_r[row_r];
  assign out_pixel_color = color_r;
  assign out_brightness  = bright_r;
  assign out_last_row    = at_last;

endmodule

@@ rtl/stxr_checker.sv @@
// Port-level checker for the scrolling text frame renderer, bound to the top level.
module stxr_checker #(
  parameter int MATRIX_HEIGHT  = 8,
  parameter int MAX_BRIGHTNESS = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_row_index,
  input logic [7:0]  out_brightness,
  input logic        out_last_row
);

  localparam int ROWS_OUT = (MATRIX_HEIGHT < stxr_pkg::STORE_ROWS) ? MATRIX_HEIGHT
                                                                    : stxr_pkg::STORE_ROWS;
  localparam logic [2:0] LAST_ROW = 3'(ROWS_OUT - 1);

  // A stalled row item holds its place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index))
    else $error("row item changed while stalled");

  // Rows of one frame follow each other without gaps
  a_row_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_row |=>
      out_valid && out_row_index == 3'($past(out_row_index) + 3'd1))
    else $error("row sequence broken");

  // A new frame starts at the top row
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_row |=> !out_valid || out_row_index == 3'd0)
    else $error("frame did not start at row 0");

  // Final row flag marks exactly the last emitted row
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == LAST_ROW)))
    else $error("last row flag misplaced");

  // Brightness never exceeds the limit
  a_bright: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_brightness <= 8'(MAX_BRIGHTNESS))
    else $error("brightness above limit");

endmodule

bind scrolling_text_frame_render_top stxr_checker #(
  .MATRIX_HEIGHT  (MATRIX_HEIGHT),
  .MAX_BRIGHTNESS (MAX_BRIGHTNESS)
) u_stxr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_row_index  (out_row_index),
  .out_brightness (out_brightness),
  .out_last_row   (out_last_row)
);
